FILE: rtl/aes_pkg.sv
// Package: AES types, S-box functions and GF(2^8) helpers.
package aes_pkg;

  localparam int RkDepth = 60;
  localparam int RkAddrW = 6;

  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_MODE = 3'd4;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  // Lane control from the round sequencer
  typedef struct packed {
    logic dec;
    logic last;
  } aes_lane_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r = r ^ x;
      x = xtime(x);
    end
    return r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] s [256];
    s = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return s[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] s [256];
    s = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return s[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

FILE: rtl/aes_lane.sv
// One column lane: S-box, MixColumns and key add for one 32-bit state column.
module aes_lane
  import aes_pkg::*;
(
  input  aes_lane_ctl_t ctl,
  input  logic [31:0]   col_in,   // column already gathered through ShiftRows
  input  logic [31:0]   rkey,
  output logic [31:0]   col_out
);

  logic [7:0]  b [4];
  logic [7:0]  m [4];
  logic [31:0] sub;
  logic [31:0] mixed;
  logic [31:0] keyed;

  // Substitution (forward or inverse)
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      b[r] = col_in[31-8*r -: 8];
      b[r] = ctl.dec ? inv_sbox(b[r]) : sbox(b[r]);
    end
    sub = {b[0], b[1], b[2], b[3]};
  end

  // Encrypt: mix then key; decrypt: key then inverse mix
  always_comb begin
    logic [31:0] src;
    src = ctl.dec ? (sub ^ rkey) : sub;
    for (int r = 0; r < 4; r++) begin
      if (ctl.dec)
        m[r] = gmul(src[31-8*r -: 8], 8'h0e) ^ gmul(src[31-8*((r+1)%4) -: 8], 8'h0b)
             ^ gmul(src[31-8*((r+2)%4) -: 8], 8'h0d) ^ gmul(src[31-8*((r+3)%4) -: 8], 8'h09);
      else
        m[r] = gmul(src[31-8*r -: 8], 8'h02) ^ gmul(src[31-8*((r+1)%4) -: 8], 8'h03)
             ^ src[31-8*((r+2)%4) -: 8] ^ src[31-8*((r+3)%4) -: 8];
    end
    mixed = {m[0], m[1], m[2], m[3]};
    keyed = src;
    if (ctl.dec)
      col_out = ctl.last ? keyed : mixed;
    else
      col_out = (ctl.last ? sub : mixed) ^ rkey;
  end

endmodule

FILE: rtl/aes_key_exp.sv
// Key expansion sequencer and round-key memory (one word per cycle).
module aes_key_exp
  import aes_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [255:0]        key,
  input  logic [1:0]          mode,
  input  logic                rd_en,
  input  logic [RkAddrW-3:0]  rd_round,
  output logic [127:0]        rd_key,
  output logic                busy
);

  logic [31:0] mem [RkDepth/4][4];
  logic [31:0] win [8];        // last nk words
  logic [RkAddrW-1:0] idx;
  logic [2:0]  pos;            // i mod nk
  logic [7:0]  rcon;
  logic [3:0]  nk;
  logic [RkAddrW-1:0] total;
  logic [31:0] t;
  logic [31:0] w_new;

  assign nk    = (mode == 2'd0) ? 4'd4 : (mode == 2'd1) ? 4'd6 : 4'd8;
  assign total = (mode == 2'd0) ? 6'd44 : (mode == 2'd1) ? 6'd52 : 6'd60;

  // Next schedule word from the window
  always_comb begin
    t = win[nk[2:0] == 3'd0 ? 3'd7 : 3'(nk - 4'd1)];
    if (idx < RkAddrW'(nk)) begin
      w_new = key[255 - 32*idx[2:0] -: 32];
    end else begin
      if (pos == 3'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
      else if (nk == 4'd8 && pos == 3'd4) t = sub_word(t);
      w_new = win[0] ^ t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      idx  <= '0;
      pos  <= '0;
      rcon <= 8'h01;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
      pos  <= '0;
      rcon <= 8'h01;
    end else if (busy) begin
      mem[idx[RkAddrW-1:2]][idx[1:0]] <= w_new;
      // shift window: win[nk-1] newest, win[0] oldest
      for (int k = 0; k < 7; k++) win[k] <= (4'(k) == nk - 4'd1) ? w_new : win[k+1];
      win[7] <= w_new;
      if (idx >= RkAddrW'(nk) && pos == 3'd0) rcon <= xtime(rcon);
      pos <= (4'(pos) == nk - 4'd1) ? 3'd0 : pos + 3'd1;
      idx <= idx + 1'b1;
      if (idx == total - 1'b1) busy <= 1'b0;
    end
  end

  // Registered round-key read
  always_ff @(posedge clk) begin
    if (rd_en)
      rd_key <= {mem[rd_round][0], mem[rd_round][1], mem[rd_round][2], mem[rd_round][3]};
  end

endmodule

FILE: rtl/aes_block_encrypt_decrypt.sv
// Top level: AES-128/192/256 round-iterative cipher with four column lanes.
//
// Input channel: in_valid/in_stall carry aes_in_t (op, block_high, block_low).
// Output channel: out_valid/out_stall carry aes_out_t (result_high, result_low).
// Config: cfg_we, cfg_index, cfg_data; indexes 0..3 key words, 4 key length.
// Any key or mode write restarts the key schedule, one round-key word per
// cycle; in_stall stays high meanwhile. Reset also expands the all-zero
// AES-128 key before the first transaction is taken.
// Each block takes one load step for the initial key add, then one round per
// cycle through the shared four-lane round datapath; each round key is read
// from the registered memory in the cycle before it is used. One block is in
// flight at a time; the next block is accepted once the output register is
// free or being drained.
// A stalled result holds in the output register and blocks new input.
module aes_block_encrypt_decrypt
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  aes_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output aes_out_t    out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [255:0] key;
  logic [1:0]   mode;
  logic         kx_busy;
  logic         kx_start;
  logic [1:0]   state;
  logic [3:0]   rnd;
  logic [3:0]   nr;
  logic         dec;
  logic [127:0] st;
  logic [127:0] rk;
  logic [127:0] shifted;
  logic [127:0] round_out;
  logic [3:0]   rd_round;
  logic         accept;
  aes_lane_ctl_t ctl;

  assign nr = (mode == 2'd0) ? 4'd10 : (mode == 2'd1) ? 4'd12 : 4'd14;

  // Configuration registers
  assign kx_start = cfg_we && (cfg_index <= CFG_MODE);
  always_ff @(posedge clk) begin
    if (rst) begin
      key  <= '0;
      mode <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0: key[255:192] <= cfg_data;
        CFG_KEY1: key[191:128] <= cfg_data;
        CFG_KEY2: key[127:64]  <= cfg_data;
        CFG_KEY3: key[63:0]    <= cfg_data;
        CFG_MODE: mode <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
        default: ;
      endcase
    end
  end

  aes_key_exp u_kx (
    .clk(clk), .rst(rst), .start(kx_start), .key(key), .mode(mode),
    .rd_en(1'b1), .rd_round(rd_round), .rd_key(rk), .busy(kx_busy)
  );

  assign in_stall = kx_busy || kx_start || state != ST_IDLE || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // Round-key index for the next cycle
  always_comb begin
    if (accept) rd_round = in_data.op ? nr : 4'd0;
    else if (dec) rd_round = rnd - 4'd1;
    else rd_round = rnd + 4'd1;
  end

  // ShiftRows (forward or inverse) gathers each lane's column
  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (dec)
          shifted[127-32*c-8*r -: 8] = st[127-32*((c+4-r)%4)-8*r -: 8];
        else
          shifted[127-32*c-8*r -: 8] = st[127-32*((c+r)%4)-8*r -: 8];
      end
  end

  assign ctl.dec   = dec;
  assign ctl.last  = dec ? (rnd == 4'd0) : (rnd == nr);

  for (genvar g = 0; g < 4; g++) begin : g_lane
    aes_lane u_lane (
      .ctl(ctl), .col_in(shifted[127-32*g -: 32]), .rkey(rk[127-32*g -: 32]),
      .col_out(round_out[127-32*g -: 32])
    );
  end

  // Round sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rnd       <= '0;
      dec       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (accept) begin
          state <= ST_LOAD;
          dec   <= in_data.op;
          rnd   <= in_data.op ? nr : 4'd0;
          st    <= {in_data.block_high, in_data.block_low};
        end
        ST_LOAD: begin
          st    <= st ^ rk;
          rnd   <= dec ? rnd - 4'd1 : rnd + 4'd1;
          state <= ST_RUN;
        end
        ST_RUN: begin
          st <= round_out;
          if (ctl.last) begin
            out_data  <= {round_out[127:64], round_out[63:0]};
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            rnd <= dec ? rnd - 4'd1 : rnd + 4'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    kx_busy |-> !accept) else $error("accepted during key expansion");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOAD) else $error("load did not follow accept");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("result lost under stall");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the AES block cipher: table-driven and random transactions.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_KEY0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  aes_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  aes_out_t    out_data;

  aes_block_encrypt_decrypt DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cipher model state
  logic [7:0]  fwd_box [256];
  logic [7:0]  inv_box [256];
  logic [63:0] key_reg [4];
  logic [1:0]  key_mode;
  logic [31:0] sched [60];

  aes_out_t expected_blocks [$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       stall_hold = 0;
  int       cycles = 0;

  function automatic logic [7:0] rot8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  // Substitution tables from the field inverse and affine map
  function automatic void build_boxes();
    logic [7:0] p, q, t;
    p = 8'h01;
    q = 8'h01;
    do begin
      p = p ^ (p << 1) ^ (p[7] ? 8'h1b : 8'h00);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      t = q ^ rot8(q, 1) ^ rot8(q, 2) ^ rot8(q, 3) ^ rot8(q, 4) ^ 8'h63;
      fwd_box[p] = t;
      inv_box[t] = p;
    end while (p != 8'h01);
    fwd_box[0] = 8'h63;
    inv_box[8'h63] = 8'h00;
  endfunction

  function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r = r ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic int key_words();
    return (key_mode > 2'd2) ? 8 : 4 + 2 * key_mode;
  endfunction

  function automatic logic [31:0] sub4(logic [31:0] w);
    return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
  endfunction

  // Key schedule into the round-key words
  function automatic void expand_schedule();
    int nk;
    logic [31:0] t;
    logic [8:0] rcon;
    nk = key_words();
    rcon = 9'h001;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = sub4({t[23:0], t[31:24]}) ^ {rcon[7:0], 24'h0};
        rcon = {rcon[7:0], 1'b0} ^ (rcon[7] ? 9'h11b : 9'h000);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub4(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
  endfunction

  function automatic void add_key(ref logic [7:0] s [16], input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[c * 4 + r] ^= sched[rnd * 4 + c][31 - 8 * r -: 8];
  endfunction

  function automatic void mix(ref logic [7:0] s [16], input logic [7:0] coef [4]);
    logic [7:0] col [4];
    logic [7:0] acc;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) col[j] = s[c * 4 + j];
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++) acc ^= field_mul(col[j], coef[(j - r) & 3]);
        s[c * 4 + r] = acc;
      end
    end
  endfunction

  function automatic void shift(ref logic [7:0] s [16], input logic inverse);
    logic [7:0] t [16];
    t = s;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inverse) s[((c + r) & 3) * 4 + r] = t[c * 4 + r];
        else s[c * 4 + r] = t[((c + r) & 3) * 4 + r];
  endfunction

  // Full encryption or decryption of one block under the current schedule
  function automatic aes_out_t cipher_block(aes_in_t x);
    logic [7:0] s [16];
    logic [127:0] blk;
    logic [7:0] fwd_coef [4];
    logic [7:0] inv_coef [4];
    int nr;
    fwd_coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    inv_coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    nr = key_words() + 6;
    blk = {x.block_high, x.block_low};
    for (int n = 0; n < 16; n++) s[n] = blk[127 - 8 * n -: 8];
    if (x.op == OP_ENC) begin
      add_key(s, 0);
      for (int rnd = 1; rnd <= nr; rnd++) begin
        for (int n = 0; n < 16; n++) s[n] = fwd_box[s[n]];
        shift(s, 1'b0);
        if (rnd != nr) mix(s, fwd_coef);
        add_key(s, rnd);
      end
    end else begin
      add_key(s, nr);
      for (int rnd = nr - 1; rnd >= 0; rnd--) begin
        shift(s, 1'b1);
        for (int n = 0; n < 16; n++) s[n] = inv_box[s[n]];
        add_key(s, rnd);
        if (rnd != 0) mix(s, inv_coef);
      end
    end
    for (int n = 0; n < 16; n++) blk[127 - 8 * n -: 8] = s[n];
    return blk;
  endfunction

  // Wait until every expected block has come back and the core is quiet
  task automatic wait_drained();
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Load a new key and mode while idle; out-of-range indexes must be ignored
  task automatic load_key(logic [255:0] key, logic [1:0] mode);
    in_valid <= 1'b0;
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= (i < 4) ? key[255 - 64 * i -: 64] :
                  (i == CFG_MODE) ? {62'd0, mode} : {$urandom, $urandom};
      @(posedge clk);
      if (i < 4) key_reg[i] = key[255 - 64 * i -: 64];
      else if (i == CFG_MODE) key_mode = mode;
    end
    cfg_we <= 1'b0;
    expand_schedule();
  endtask

  // Offer one transaction, hold it until accepted, then record the expected block
  task automatic send_block(logic op, logic [127:0] blk);
    aes_in_t x;
    x = '{op: op, block_high: blk[127:64], block_low: blk[63:0]};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_stall);
    expected_blocks.push_back(cipher_block(x));
  endtask

  // Result monitor
  always @(posedge clk) begin
    aes_out_t exp_blk;
    if (!rst && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (out_data.result_high !== exp_blk.result_high) begin
          $display("%0t: result_high expected %h actual %h", $time,
                   exp_blk.result_high, out_data.result_high);
          errors++;
        end
        if (out_data.result_low !== exp_blk.result_low) begin
          $display("%0t: result_low expected %h actual %h", $time,
                   exp_blk.result_low, out_data.result_low);
          errors++;
        end
      end
    end
  end

  // Receiver stall generation, with a counted long hold-off
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  typedef struct {
    logic         new_key;
    logic [1:0]   mode;
    logic [255:0] key;
    logic         op;
    logic [127:0] blk;
    logic         known;
    logic [127:0] result;
  } vector_t;

  localparam logic [255:0] Key128 =
    256'h000102030405060708090a0b0c0d0e0f_00000000000000000000000000000000;
  localparam logic [255:0] Key192 =
    256'h000102030405060708090a0b0c0d0e0f1011121314151617_0000000000000000;
  localparam logic [255:0] Key256 =
    256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;
  localparam logic [127:0] Plain = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] Ones = '1;

  vector_t directed [] = '{
    '{1'b0, 2'd0, '0, OP_ENC, '0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{1'b0, 2'd0, '0, OP_DEC, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1, '0},
    '{1'b0, 2'd0, '0, OP_ENC, Ones, 1'b0, '0},
    '{1'b0, 2'd0, '0, OP_DEC, Ones, 1'b0, '0},
    '{1'b1, 2'd0, Key128, OP_ENC, Plain, 1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{1'b0, 2'd0, Key128, OP_DEC, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1, Plain},
    '{1'b1, 2'd1, Key192, OP_ENC, Plain, 1'b1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191},
    '{1'b0, 2'd1, Key192, OP_DEC, 128'hdda97ca4864cdfe06eaf70a0ec0d7191, 1'b1, Plain},
    '{1'b1, 2'd2, Key256, OP_ENC, Plain, 1'b1, 128'h8ea2b7ca516745bfeafc49904b496089},
    '{1'b0, 2'd2, Key256, OP_DEC, 128'h8ea2b7ca516745bfeafc49904b496089, 1'b1, Plain},
    // mode three behaves as a 256-bit key
    '{1'b1, 2'd3, Key256, OP_ENC, Plain, 1'b1, 128'h8ea2b7ca516745bfeafc49904b496089},
    '{1'b0, 2'd3, Key256, OP_DEC, Ones, 1'b0, '0},
    '{1'b1, 2'd2, '1, OP_ENC, '0, 1'b0, '0},
    '{1'b0, 2'd2, '1, OP_DEC, Ones, 1'b0, '0},
    // upper key bytes must not matter for a 128-bit key
    '{1'b1, 2'd0, {Key128[255:128], 128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff},
      OP_ENC, Plain, 1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{1'b1, 2'd1, '1, OP_ENC, Ones, 1'b0, '0}
  };

  function automatic logic [127:0] random_block();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [255:0] key;
    build_boxes();
    key_reg = '{default: '0};
    key_mode = 2'd0;
    expand_schedule();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table; rows with a typed-in result override the prediction
    foreach (directed[i]) begin
      if (directed[i].new_key) load_key(directed[i].key, directed[i].mode);
      send_block(directed[i].op, directed[i].blk);
      if (directed[i].known) expected_blocks[$] = directed[i].result;
    end
    in_valid <= 1'b0;

    // Random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 74 : 0;
      recv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 32 : 0;
      for (int n = 0; n < 212; n++) begin
        if (n % 53 == 0) begin
          in_valid <= 1'b0;
          case ($urandom_range(5))
            0: key = '0;
            1: key = '1;
            default: key = {$urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom};
          endcase
          load_key(key, 2'($urandom_range(3)));
        end
        // long receiver hold-off with the sender pushing back to back
        if (phase == 2 && n == 100) stall_hold = 300;
        // sender pause until everything has come back
        if (n == 150) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_block(1'($urandom_range(1)), random_block());
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/aes_pkg.sv
rtl/aes_lane.sv
rtl/aes_key_exp.sv
rtl/aes_block_encrypt_decrypt.sv
tb/tb.sv
